>>> rtl/core/sntw_pkg.sv
`default_nettype none
package sntw_pkg;

  localparam int unsigned SNTW_WINDOW = 1024;

  localparam int unsigned BYTES_W = 26;
  localparam int unsigned PKTS_W  = 11;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PEEK = 1'b1
  } cmd_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] length;
  } entry_t;

  // window check of a peeked number
  typedef struct packed {
    logic hit;   // number lies in trail..lead of a non-empty window
    logic wrap;  // number sits past the 2^32 wrap as seen from trail
  } lookup_t;

endpackage
`default_nettype wire

>>> rtl/core/sequence_numbered_transmit_window.sv
`default_nettype none
// channel  dir  beat fields
// -------  ---  -------------------------------------------------------------
// s_*      in   tuser: cmd; tdata: seq_number, buffer_handle, entry_length
// m_*      out  tuser: status, evicted; tdata: result_seq, result_handle,
//                result_length, evicted_handle, bytes_total, packets_total
//
// each beat reads the slot ram at accept; the update cycle (S_EXEC) then
// updates the counters, writes the slot back and loads the output register.
// the slot ram has one read and one write port. synchronous reset empties
// the window (lead 0, trail 1) and clears the totals; the slot ram is not
// cleared. a result waiting at m_* holds the update cycle of the next beat.
module sequence_numbered_transmit_window
  import sntw_pkg::*;
#(
  parameter int unsigned WINDOW = SNTW_WINDOW
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [79:0]  s_tdata,   // seq_number, buffer_handle, entry_length
  input  wire logic [0:0]   s_tuser,   // cmd
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [151:0]      m_tdata,   // result_seq, result_handle, result_length,
                                       // evicted_handle, bytes_total, packets_total
  output logic [1:0]        m_tuser    // status, evicted
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [31:0]        lead_seq;
  logic [31:0]        trail_seq;
  logic [AW-1:0]      lead_slot;
  logic [AW-1:0]      trail_slot;
  logic [BYTES_W-1:0] byte_count;
  logic [PKTS_W-1:0]  packet_count;

  cmd_t        op;
  logic [31:0] op_seq;
  logic [31:0] op_handle;
  logic [15:0] op_length;
  logic        op_hit;
  logic        op_full;

  logic               o_status;
  logic [31:0]        o_rseq;
  logic [31:0]        o_rhandle;
  logic [15:0]        o_rlength;
  logic               o_evicted;
  logic [31:0]        o_evhandle;

  logic               accept;
  logic               out_free;
  logic               commit;
  cmd_t               in_cmd;
  logic [31:0]        fill;
  logic               full;
  lookup_t            look;
  logic [AW-1:0]      peek_slot;
  logic [AW-1:0]      raddr;
  entry_t             rd;
  entry_t             wdata;
  logic [31:0]        lead_inc;
  logic [31:0]        trail_inc;
  logic [AW-1:0]      lead_slot_next;
  logic [AW-1:0]      trail_slot_next;
  logic [BYTES_W-1:0] byte_count_next;

  assign in_cmd   = cmd_t'(s_tuser[0]);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == S_EXEC) && out_free;

  assign fill = lead_seq - trail_seq + 32'd1;
  assign full = (fill == 32'(WINDOW));

  sntw_lookup #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_lookup (
    .seq        (s_tdata[31:0]),
    .lead       (lead_seq),
    .trail      (trail_seq),
    .trail_slot (trail_slot),
    .look       (look),
    .slot       (peek_slot)
  );

  // push reads the trail slot for a possible eviction
  assign raddr = (in_cmd == CMD_PUSH) ? trail_slot : peek_slot;

  // slot index steps by one, back to zero after WINDOW-1 or across the 2^32 wrap
  assign lead_inc  = lead_seq + 32'd1;
  assign trail_inc = trail_seq + 32'd1;
  assign lead_slot_next  = (lead_inc == '0 || lead_slot == AW'(WINDOW - 1)) ?
                           '0 : lead_slot + AW'(1);
  assign trail_slot_next = (trail_inc == '0 || trail_slot == AW'(WINDOW - 1)) ?
                           '0 : trail_slot + AW'(1);

  assign wdata.handle = op_handle;
  assign wdata.length = op_length;

  sntw_ram #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (commit && op == CMD_PUSH),
    .waddr (lead_slot_next),
    .wdata (wdata),
    .re    (accept),
    .raddr (raddr),
    .rdata (rd)
  );

  assign byte_count_next = byte_count + BYTES_W'(op_length)
                         - (op_full ? BYTES_W'(rd.length) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m_tvalid     <= 1'b0;
      lead_seq     <= 32'd0;
      trail_seq    <= 32'd1;
      lead_slot    <= '0;
      trail_slot   <= AW'(1);
      byte_count   <= '0;
      packet_count <= '0;
    end else begin
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= in_cmd;
            op_seq    <= s_tdata[31:0];
            op_handle <= s_tdata[63:32];
            op_length <= s_tdata[79:64];
            op_hit    <= look.hit;
            op_full   <= full;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state    <= S_IDLE;
            if (op == CMD_PUSH) begin
              lead_seq   <= lead_inc;
              lead_slot  <= lead_slot_next;
              byte_count <= byte_count_next;
              if (op_full) begin
                trail_seq  <= trail_inc;
                trail_slot <= trail_slot_next;
              end else begin
                packet_count <= packet_count + PKTS_W'(1);
              end
              o_status   <= STATUS_OK;
              o_rseq     <= lead_inc;
              o_rhandle  <= '0;
              o_rlength  <= '0;
              o_evicted  <= op_full;
              o_evhandle <= op_full ? rd.handle : '0;
            end else begin
              o_status   <= op_hit ? STATUS_OK : STATUS_MISS;
              o_rseq     <= op_seq;
              o_rhandle  <= op_hit ? rd.handle : '0;
              o_rlength  <= op_hit ? rd.length : '0;
              o_evicted  <= 1'b0;
              o_evhandle <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, packet_count, byte_count, o_evhandle,
                    o_rlength, o_rhandle, o_rseq};
  assign m_tuser = {o_evicted, o_status};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 32'(WINDOW))
    else $error("window holds more than WINDOW packets");

  a_count_fill: assert property (@(posedge clk) disable iff (rst)
    packet_count == fill[PKTS_W-1:0])
    else $error("packet count disagrees with lead and trail");

  a_one_pending: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second beat taken while one is in the update cycle");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> m_tvalid)
    else $error("update cycle left no result");

  a_push_steps: assert property (@(posedge clk) disable iff (rst)
    (commit && op == CMD_PUSH) |=> (lead_seq == $past(lead_seq) + 32'd1))
    else $error("push did not advance lead");

endmodule
`default_nettype wire

>>> rtl/core/sntw_ram.sv
`default_nettype none
module sntw_ram
  import sntw_pkg::*;
#(
  parameter int unsigned DEPTH = SNTW_WINDOW,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sntw_lookup.sv
`default_nettype none
module sntw_lookup
  import sntw_pkg::*;
#(
  parameter int unsigned WINDOW = SNTW_WINDOW,
  parameter int unsigned AW     = $clog2(WINDOW)
) (
  input  wire logic [31:0]   seq,
  input  wire logic [31:0]   lead,
  input  wire logic [31:0]   trail,
  input  wire logic [AW-1:0] trail_slot,
  output lookup_t            look,
  output logic [AW-1:0]      slot
);

  // residue of 2^32, applied when the offset from trail crosses the wrap
  localparam logic [63:0]   WRAP64 = 64'h1_0000_0000 % 64'(WINDOW);
  localparam logic [AW+1:0] WRAP_C = WRAP64[AW+1:0];
  localparam logic [AW+1:0] WIN_C  = (AW+2)'(WINDOW);

  logic [31:0]   from_trail;
  logic [31:0]   ahead;
  logic          empty;
  logic [AW+1:0] sum;
  logic [AW+1:0] adj;

  assign from_trail = seq - trail;
  assign ahead      = lead - seq;
  assign empty      = (trail == lead + 32'd1);

  assign look.hit  = !empty && !from_trail[31] && !ahead[31];
  assign look.wrap = (seq < trail);

  // offset is below WINDOW on a hit, so one correction either way suffices
  assign sum = {2'b00, trail_slot} + {2'b00, from_trail[AW-1:0]};
  assign adj = sum - (look.wrap ? WRAP_C : '0);

  always_comb begin
    if (adj[AW+1]) begin
      slot = AW'(adj + WIN_C);
    end else if (adj >= WIN_C) begin
      slot = AW'(adj - WIN_C);
    end else begin
      slot = adj[AW-1:0];
    end
  end

endmodule
`default_nettype wire
